/* hdl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths, command and phase codes, and item/entry types for the
// LED profile sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int NUM_LEDS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CMD_W = 3;
  localparam int LED_W = 5;
  localparam int MS_W = 16;
  localparam int COLOR_W = 32;
  localparam int PH_W = 2;

  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ON = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OFF = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OFF_ALL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd5;

  localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PH_W-1:0] PH_DELAY = 2'd1;
  localparam logic [PH_W-1:0] PH_FIRST = 2'd2;
  localparam logic [PH_W-1:0] PH_HOLD = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic               scan;
    logic [LED_W-1:0]   led;
    logic [MS_W-1:0]    delay_ms;
    logic [COLOR_W-1:0] first_color;
    logic [MS_W-1:0]    first_ms;
    logic [COLOR_W-1:0] hold_color;
  } q_item_t;

  typedef struct packed {
    logic [PH_W-1:0]    phase;
    logic [MS_W-1:0]    start_ms;
    logic [MS_W-1:0]    delay_ms;
    logic [COLOR_W-1:0] first_color;
    logic [MS_W-1:0]    first_ms;
    logic [COLOR_W-1:0] hold_color;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    phase:       PH_IDLE,
    start_ms:    16'd0,
    delay_ms:    16'd0,
    first_color: 32'd127,
    first_ms:    16'd50,
    hold_color:  32'd0
  };

endpackage

/* hdl/led_profile_sequencer_top.sv */
// ----------------------------------------------------------------------------
// led_profile_sequencer_top
// Per-LED timed colour sequencer: tick, on, off, toggle, off-all and profile
// write commands; every colour change leaves as one pixel write item.
// The back end runs one command at a time as a read/update/write pass over the
// entry memory, one entry per cycle while the output is not stalled: a single
// LED command visits its own entry, a tick or off-all every entry.
// Output stalls hold the pass. Reset (rst_n low, synchronous) clears phases,
// time and profiles to their defaults at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module led_profile_sequencer_top #(
  parameter int NUM_LEDS = lps_pkg::NUM_LEDS_DEF,
  parameter int QUEUE_DEPTH = lps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // led_index, delay_ms, first_color, first_ms, hold_color, zero pad
  input  logic [lps_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [lps_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_index, pixel_color, zero pad
  output logic [lps_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  logic                        q_full;
  logic                        q_push;
  lps_pkg::q_item_t            q_push_item;
  logic                        q_pop;
  logic                        q_vld;
  lps_pkg::q_item_t            q_item;
  logic [lps_pkg::LED_W-1:0]   pixel_index;
  logic [lps_pkg::COLOR_W-1:0] pixel_color;

  lps_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  lps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .vld       (q_vld),
    .item      (q_item)
  );

  lps_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_index (pixel_index),
    .out_color (pixel_color),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, pixel_color, pixel_index};

endmodule

/* hdl/lps_front.sv */
// ----------------------------------------------------------------------------
// lps_front
// Input side: unpacks each item, drops unknown commands and out-of-range LED
// indexes, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module lps_front #(
  parameter int NUM_LEDS = lps_pkg::NUM_LEDS_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // led_index, delay_ms, first_color, first_ms, hold_color, zero pad
  input  logic [lps_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [lps_pkg::CMD_W-1:0]      in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output lps_pkg::q_item_t               q_item
);

  logic led_ok;
  logic keep;

  assign in_tready = !q_full;

  always_comb begin
    q_item.op          = in_tuser;
    q_item.led         = in_tdata[4:0];
    q_item.delay_ms    = in_tdata[20:5];
    q_item.first_color = in_tdata[52:21];
    q_item.first_ms    = in_tdata[68:53];
    q_item.hold_color  = in_tdata[100:69];
    q_item.scan        = (in_tuser == lps_pkg::CMD_TICK) ||
                         (in_tuser == lps_pkg::CMD_OFF_ALL);
  end

  assign led_ok = 32'(in_tdata[4:0]) < NUM_LEDS;

  always_comb begin
    case (in_tuser)
      lps_pkg::CMD_TICK,
      lps_pkg::CMD_OFF_ALL: keep = 1'b1;
      lps_pkg::CMD_ON,
      lps_pkg::CMD_OFF,
      lps_pkg::CMD_TOGGLE,
      lps_pkg::CMD_WRITE:   keep = led_ok;
      default:              keep = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && in_tready && keep;

endmodule

/* hdl/lps_fifo.sv */
// ----------------------------------------------------------------------------
// lps_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lps_fifo #(
  parameter int DEPTH = lps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lps_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             vld,
  output lps_pkg::q_item_t item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lps_pkg::q_item_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;

  assign full = (count_r == (AW+1)'(DEPTH));
  assign vld  = (count_r != '0);
  assign item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hdl/lps_back.sv */
// ----------------------------------------------------------------------------
// lps_back
// Executes queued commands against the per-LED entry memory. Entries are
// read, updated and written back through a one-stage pipeline; colour writes
// pass through a holding register so the final one of a command gets last.
// ----------------------------------------------------------------------------
module lps_back #(
  parameter int NUM_LEDS = lps_pkg::NUM_LEDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_vld,
  input  lps_pkg::q_item_t             q_item,
  output logic                         q_pop,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic [lps_pkg::LED_W-1:0]    out_index,
  output logic [lps_pkg::COLOR_W-1:0]  out_color,
  output logic                         out_last
);

  localparam int IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  lps_pkg::q_item_t            cmd_r;
  logic [lps_pkg::MS_W-1:0]    now_r;

  lps_pkg::entry_t             mem_r [NUM_LEDS];
  logic [NUM_LEDS-1:0]         ent_vld_r;
  lps_pkg::entry_t             rd_q_r;
  logic                        rd_vld_r;

  logic [IW-1:0]               iss_cnt_r;
  logic [IW-1:0]               iss_end_r;
  logic                        iss_more_r;
  logic                        p_vld_r;
  logic [IW-1:0]               p_idx_r;

  logic                        pend_vld_r;
  logic [lps_pkg::LED_W-1:0]   pend_idx_r;
  logic [lps_pkg::COLOR_W-1:0] pend_col_r;

  logic                        out_vld_r;
  logic [lps_pkg::LED_W-1:0]   out_idx_r;
  logic [lps_pkg::COLOR_W-1:0] out_col_r;
  logic                        out_last_r;

  logic                        out_ok;
  logic                        adv;
  logic                        rd_en;
  logic                        wr_en;
  logic                        flush_go;

  lps_pkg::entry_t             e_cur;
  lps_pkg::entry_t             e_new;
  logic [lps_pkg::MS_W-1:0]    elapsed;
  logic                        emit;
  logic [lps_pkg::COLOR_W-1:0] emit_col;
  logic                        do_on;
  logic                        do_off;

  assign out_ok   = !out_vld_r || out_rdy;
  assign adv      = !p_vld_r || out_ok;
  assign rd_en    = (state_r == ST_RUN) && adv && iss_more_r;
  assign wr_en    = (state_r == ST_RUN) && adv && p_vld_r;
  assign q_pop    = (state_r == ST_IDLE) && q_vld;
  assign flush_go = (state_r == ST_FLUSH) && pend_vld_r && out_ok;

  assign out_vld   = out_vld_r;
  assign out_index = out_idx_r;
  assign out_color = out_col_r;
  assign out_last  = out_last_r;

  // entry update
  always_comb begin
    e_cur    = rd_vld_r ? rd_q_r : lps_pkg::ENTRY_RST;
    e_new    = e_cur;
    emit     = 1'b0;
    emit_col = '0;
    do_on    = 1'b0;
    do_off   = 1'b0;
    elapsed  = now_r - e_cur.start_ms;
    case (cmd_r.op)
      lps_pkg::CMD_TICK: begin
        case (e_cur.phase)
          lps_pkg::PH_DELAY: begin
            if (elapsed >= e_cur.delay_ms) begin
              emit           = 1'b1;
              emit_col       = e_cur.first_color;
              e_new.phase    = lps_pkg::PH_FIRST;
              e_new.start_ms = now_r;
            end
          end
          lps_pkg::PH_FIRST: begin
            if (elapsed >= e_cur.first_ms) begin
              emit = 1'b1;
              if (e_cur.hold_color != '0) begin
                emit_col    = e_cur.hold_color;
                e_new.phase = lps_pkg::PH_HOLD;
              end else begin
                emit_col    = '0;
                e_new.phase = lps_pkg::PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      lps_pkg::CMD_ON:      do_on = 1'b1;
      lps_pkg::CMD_OFF,
      lps_pkg::CMD_OFF_ALL: do_off = 1'b1;
      lps_pkg::CMD_TOGGLE: begin
        if (e_cur.phase != lps_pkg::PH_IDLE) begin
          do_off = 1'b1;
        end else begin
          do_on = 1'b1;
        end
      end
      lps_pkg::CMD_WRITE: begin
        e_new.delay_ms    = cmd_r.delay_ms;
        e_new.first_color = cmd_r.first_color;
        e_new.first_ms    = cmd_r.first_ms;
        e_new.hold_color  = cmd_r.hold_color;
      end
      default: ;
    endcase
    if (do_on && ((e_cur.phase == lps_pkg::PH_IDLE) || (e_cur.phase == lps_pkg::PH_HOLD))) begin
      emit           = 1'b1;
      e_new.start_ms = now_r;
      if (e_cur.delay_ms != '0) begin
        emit_col    = '0;
        e_new.phase = lps_pkg::PH_DELAY;
      end else if (e_cur.first_ms == '0) begin
        emit_col    = e_cur.hold_color;
        e_new.phase = lps_pkg::PH_HOLD;
      end else begin
        emit_col    = e_cur.first_color;
        e_new.phase = lps_pkg::PH_FIRST;
      end
    end
    if (do_off && (e_cur.hold_color != '0)) begin
      emit        = 1'b1;
      emit_col    = '0;
      e_new.phase = lps_pkg::PH_IDLE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!iss_more_r && !p_vld_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r || out_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[p_idx_r] <= e_new;
    end
    if (rd_en) begin
      rd_q_r   <= mem_r[iss_cnt_r];
      rd_vld_r <= ent_vld_r[iss_cnt_r];
      p_idx_r  <= iss_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_item;
    end
    if (q_pop) begin
      if (q_item.scan) begin
        iss_cnt_r <= '0;
        iss_end_r <= IW'(NUM_LEDS-1);
      end else begin
        iss_cnt_r <= IW'(q_item.led);
        iss_end_r <= IW'(q_item.led);
      end
    end else if (rd_en) begin
      iss_cnt_r <= iss_cnt_r + 1'b1;
    end
    if (wr_en && emit) begin
      pend_idx_r <= lps_pkg::LED_W'(p_idx_r);
      pend_col_r <= emit_col;
    end
    if ((wr_en && emit && pend_vld_r) || flush_go) begin
      out_idx_r  <= pend_idx_r;
      out_col_r  <= pend_col_r;
      out_last_r <= flush_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      now_r      <= '0;
      ent_vld_r  <= '0;
      iss_more_r <= 1'b0;
      p_vld_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && (q_item.op == lps_pkg::CMD_TICK)) begin
        now_r <= now_r + 1'b1;
      end
      if (wr_en) begin
        ent_vld_r[p_idx_r] <= 1'b1;
      end
      if (q_pop) begin
        iss_more_r <= 1'b1;
      end else if (rd_en && (iss_cnt_r == iss_end_r)) begin
        iss_more_r <= 1'b0;
      end
      if ((state_r == ST_RUN) && adv) begin
        p_vld_r <= iss_more_r;
      end
      if (wr_en && emit) begin
        pend_vld_r <= 1'b1;
      end else if (flush_go) begin
        pend_vld_r <= 1'b0;
      end
      if ((wr_en && emit && pend_vld_r) || flush_go) begin
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!p_vld_r && !pend_vld_r && !iss_more_r))
    else $error("command started with work still in flight");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (iss_cnt_r != p_idx_r))
    else $error("entry read and written at the same address");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && emit && pend_vld_r) |-> out_ok)
    else $error("held colour write pushed into a full output register");

  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && pend_vld_r && out_ok) |=> (out_vld_r && out_last_r))
    else $error("final colour write of a command not marked last");

endmodule
